// ----- design/rvalu_pkg.sv -----
// Shared types and operation codes for the RV32IM integer ALU.
// No dependencies.
package rvalu_pkg;

	localparam int unsigned XLEN = 32;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_SUB    = 5'd1,
		OP_SLL    = 5'd2,
		OP_SLT    = 5'd3,
		OP_SLTU   = 5'd4,
		OP_XOR    = 5'd5,
		OP_SRL    = 5'd6,
		OP_SRA    = 5'd7,
		OP_OR     = 5'd8,
		OP_AND    = 5'd9,
		OP_MUL    = 5'd10,
		OP_MULH   = 5'd11,
		OP_MULHSU = 5'd12,
		OP_MULHU  = 5'd13,
		OP_DIV    = 5'd14,
		OP_DIVU   = 5'd15,
		OP_REM    = 5'd16,
		OP_REMU   = 5'd17,
		OP_LUI    = 5'd18,
		OP_AUIPC  = 5'd19
	} op_e;

	typedef enum logic [1:0] {
		K_PASS = 2'd0,
		K_QUO  = 2'd1,
		K_REM  = 2'd2
	} kind_e;

	typedef struct packed {
		logic [4:0]  op;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [31:0] pc_value;
		logic [4:0]  dest_index;
	} cmd_t;

	typedef struct packed {
		logic [31:0] value;
		logic [4:0]  write_index;
		logic        illegal;
	} res_t;

	// Work carried from cell to cell: divider state plus the finished result
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] dvs;
		logic [31:0] res;
		kind_e       kind;
		logic        neg;
		logic        bzero;
		logic        illegal;
		logic [4:0]  dest;
	} lane_t;

endpackage

// ----- design/rvalu_div_cell.sv -----
// One cell of the divider chain: a single restoring division step.
// Depends on rvalu_pkg.
module rvalu_div_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  rvalu_pkg::lane_t     in_lane,
	output logic                 out_valid,
	output rvalu_pkg::lane_t     out_lane
);
	import rvalu_pkg::*;

	logic        valid_q;
	lane_t       lane_q;
	lane_t       nxt;
	logic [32:0] trial;
	logic [32:0] diff;

	// Shift in the next dividend bit, subtract the divisor when it fits
	always_comb begin
		nxt   = in_lane;
		trial = {in_lane.rem, in_lane.quo[31]};
		diff  = trial - {1'b0, in_lane.dvs};
		if (!diff[32]) begin
			nxt.rem = diff[31:0];
			nxt.quo = {in_lane.quo[30:0], 1'b1};
		end else begin
			nxt.rem = trial[31:0];
			nxt.quo = {in_lane.quo[30:0], 1'b0};
		end
	end

	// Advance valid with the whole chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lane_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_lane  = lane_q;

endmodule

// ----- design/rv32im_integer_alu.sv -----
// Top level of the RV32IM integer ALU: decode, multiply and the divider chain.
// Depends on rvalu_pkg and rvalu_div_cell.
//
// Takes one request per cycle while the chain is not held, and returns one result per
// request, in order. The path holds 34 registers: an input register, 32 divider
// cells (one quotient bit each) and the output register. The operate/multiply
// logic sits between the input register and the first cell. Every operation
// walks the same chain so results never reorder. The whole chain advances
// together and holds while a finished result waits under res_stall.
module rv32im_integer_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  rvalu_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output rvalu_pkg::res_t   res
);
	import rvalu_pkg::*;

	localparam int unsigned NCELL = XLEN;

	logic        adv;
	logic        v_s1;
	cmd_t        cmd_s1;
	logic        v_q;
	res_t        res_q;
	lane_t       lane0;
	logic        cv   [NCELL+1];
	lane_t       cl   [NCELL+1];
	logic [32:0] ma;
	logic [32:0] mb;
	logic [65:0] prod;
	logic [4:0]  sh;
	logic        sa;
	logic        sb;
	res_t        fin;
	logic [31:0] qv;
	logic [31:0] rv;

	// Move everything one step whenever the output can take a result
	assign adv       = !v_q || !res_stall;
	assign cmd_stall = !adv;

	// Hold the request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
		end
	end

	// Operate: simple ops, multiply, and divider setup
	always_comb begin
		sh = cmd_s1.operand_b[4:0];
		sa = cmd_s1.operand_a[31];
		sb = cmd_s1.operand_b[31];
		ma = {1'b0, cmd_s1.operand_a};
		mb = {1'b0, cmd_s1.operand_b};
		if (cmd_s1.op == OP_MULH || cmd_s1.op == OP_MULHSU) begin
			ma = {sa, cmd_s1.operand_a};
		end
		if (cmd_s1.op == OP_MULH) begin
			mb = {sb, cmd_s1.operand_b};
		end
		prod = 66'($signed(ma) * $signed(mb));

		lane0.rem     = '0;
		lane0.quo     = cmd_s1.operand_a;
		lane0.dvs     = cmd_s1.operand_b;
		lane0.res     = '0;
		lane0.kind    = K_PASS;
		lane0.neg     = 1'b0;
		lane0.bzero   = (cmd_s1.operand_b == '0);
		lane0.illegal = 1'b0;
		lane0.dest    = cmd_s1.dest_index;

		unique case (cmd_s1.op)
			OP_ADD:    lane0.res = cmd_s1.operand_a + cmd_s1.operand_b;
			OP_SUB:    lane0.res = cmd_s1.operand_a - cmd_s1.operand_b;
			OP_SLL:    lane0.res = cmd_s1.operand_a << sh;
			OP_SLT:    lane0.res = {31'd0,
				$signed(cmd_s1.operand_a) < $signed(cmd_s1.operand_b)};
			OP_SLTU:   lane0.res = {31'd0, cmd_s1.operand_a < cmd_s1.operand_b};
			OP_XOR:    lane0.res = cmd_s1.operand_a ^ cmd_s1.operand_b;
			OP_SRL:    lane0.res = cmd_s1.operand_a >> sh;
			OP_SRA:    lane0.res = 32'($signed(cmd_s1.operand_a) >>> sh);
			OP_OR:     lane0.res = cmd_s1.operand_a | cmd_s1.operand_b;
			OP_AND:    lane0.res = cmd_s1.operand_a & cmd_s1.operand_b;
			OP_MUL:    lane0.res = prod[31:0];
			OP_MULH, OP_MULHSU, OP_MULHU: lane0.res = prod[63:32];
			OP_DIV: begin
				lane0.kind = K_QUO;
				lane0.neg  = sa ^ sb;
				lane0.quo  = sa ? -cmd_s1.operand_a : cmd_s1.operand_a;
				lane0.dvs  = sb ? -cmd_s1.operand_b : cmd_s1.operand_b;
			end
			OP_REM: begin
				lane0.kind = K_REM;
				lane0.neg  = sa;
				lane0.quo  = sa ? -cmd_s1.operand_a : cmd_s1.operand_a;
				lane0.dvs  = sb ? -cmd_s1.operand_b : cmd_s1.operand_b;
			end
			OP_DIVU:   lane0.kind = K_QUO;
			OP_REMU:   lane0.kind = K_REM;
			OP_LUI:    lane0.res = cmd_s1.operand_a;
			OP_AUIPC:  lane0.res = cmd_s1.pc_value + cmd_s1.operand_a;
			default:   lane0.illegal = 1'b1;
		endcase
	end

	assign cv[0] = v_s1;
	assign cl[0] = lane0;

	// Chain of division cells, one quotient bit per cell
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		rvalu_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (cv[i]),
			.in_lane   (cl[i]),
			.out_valid (cv[i+1]),
			.out_lane  (cl[i+1])
		);
	end

	// Fix signs and pick the result at the end of the chain
	always_comb begin
		qv = cl[NCELL].neg ? -cl[NCELL].quo : cl[NCELL].quo;
		rv = cl[NCELL].neg ? -cl[NCELL].rem : cl[NCELL].rem;
		fin.write_index = cl[NCELL].dest;
		fin.illegal     = cl[NCELL].illegal;
		case (cl[NCELL].kind)
			K_QUO:   fin.value = cl[NCELL].bzero ? '1 : qv;
			K_REM:   fin.value = rv;
			default: fin.value = cl[NCELL].res;
		endcase
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= cv[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= fin;
		end
	end

	assign res_valid = v_q;
	assign res       = res_q;

endmodule
